[rtl/core/assert_macros.svh]
// Assertion helpers for the tour search unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off during reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(lbl, cond, msg) \
   `ASSERT_CLK(lbl, !(cond), msg)

`endif

[rtl/core/tnn2o_pkg.sv]
// ----------------------------------------------------------------------------
// Tour search package
// Shared types and constants of the nearest-neighbour / 2-opt tour unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tnn2o_pkg;

   localparam int VTX_W  = 5;
   localparam int POS_W  = 5;
   localparam int COST_W = 21;
   localparam int ROW_W  = 5;
   localparam int WIN_W  = 16;
   localparam int VC_W   = 6;

   localparam logic [COST_W-1:0] COST_MAX = 21'h1FFFFF;
   localparam logic [VC_W-1:0]   VC_RESET = 6'd32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LD2, ST_INIT,
      ST_NN_SCAN, ST_NN_LAST, ST_NN_LINK1, ST_NN_LINK2,
      ST_W0, ST_W1, ST_WA, ST_WB, ST_WDONE,
      ST_I0, ST_I1, ST_I2, ST_I3,
      ST_J0, ST_J1, ST_J2, ST_J3, ST_J4, ST_J5,
      ST_R0, ST_R1, ST_E0, ST_E1
   } st_type;

   typedef struct packed {
      logic              valid;
      logic [VTX_W-1:0]  vertex;
      logic [POS_W-1:0]  position;
      logic [COST_W-1:0] tour_cost;
      logic              last;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/core/tnn2o_wmem.sv]
// ----------------------------------------------------------------------------
// Weight store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tnn2o_wmem #(
   parameter int VB = 5,
   parameter int WB = 16
) (
   input  logic            clock,
   input  logic            we,
   input  logic [2*VB-1:0] waddr,
   input  logic [WB-1:0]   wdata,
   input  logic [2*VB-1:0] raddr,
   output logic [WB-1:0]   rdata
);

   logic [WB-1:0] store_ff [2**(2*VB)];
   logic [WB-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/core/tnn2o_seq.sv]
// ----------------------------------------------------------------------------
// Tour sequencer
// Builds the nearest-neighbour tour, runs 2-opt passes over it with one
// shared adder, and emits the final tour one vertex at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tnn2o_seq #(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16,
   parameter int VB = $clog2(MAX_VERTICES),
   parameter int CB = $clog2(MAX_VERTICES + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [tnn2o_pkg::ROW_W-1:0]  req_row,
   input  logic [tnn2o_pkg::ROW_W-1:0]  req_col,
   input  logic [tnn2o_pkg::WIN_W-1:0]  req_weight,
   input  logic [CB-1:0]                n_active,
   input  logic                         out_free,
   output tnn2o_pkg::rsp_item_type      emit,
   output logic                         mem_we,
   output logic [2*VB-1:0]              mem_waddr,
   output logic [WEIGHT_BITS-1:0]       mem_wdata,
   output logic [2*VB-1:0]              mem_raddr,
   input  logic [WEIGHT_BITS-1:0]       mem_rdata
);

   import tnn2o_pkg::*;

   localparam int WB    = WEIGHT_BITS;
   localparam int SUM_W = ((WB > COST_W) ? WB : COST_W) + 1;

   st_type state_ff, state_in;

   logic [CB-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in, k_ff, k_in, nm1, ip1, jp1;
   logic [VB-1:0] v_ff, v_in, pick_ff, pick_in, prev_ff, prev_in, cur_ff, cur_in;
   logic [VB-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [VB-1:0] idx_ff, idx_in, lrow_ff, lrow_in, lcol_ff, lcol_in;
   logic          have_ff, have_in, cand_ff, cand_in, pend_ff, pend_in, lok_ff, lok_in;
   logic [WB-1:0] best_ff, best_in, wab_ff, wab_in, wac_ff, wac_in, lw_ff, lw_in;
   logic [WB:0]   s1_ff, s1_in;
   logic [COST_W-1:0] acc_ff, acc_in, acc_sat;
   logic [1:0]    rl_ff, rl_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;

   logic [VB-1:0] nf_ff [MAX_VERTICES];
   logic [VB-1:0] ns_ff [MAX_VERTICES];
   logic [VB-1:0] tl_ff [MAX_VERTICES];
   logic [VB-1:0] nf_q_ff, ns_q_ff, tl_q_ff;
   logic [VB-1:0] nb_ra, tl_ra, nf_wa, nf_wd, ns_wa, ns_wd, tl_wa, tl_wd;
   logic          nf_we, ns_we, tl_we;

   logic [SUM_W-1:0] alu_a, alu_sum;
   logic [VB-1:0]    nsel, walk_nxt, rv, rdrop, radd, pk;
   logic             ld_ok, upd, skip, better;

   assign nm1 = n_ff - CB'(1);
   assign ip1 = i_ff + CB'(1);
   assign jp1 = j_ff + CB'(1);
   assign ld_ok = (int'(req_row) < MAX_VERTICES) && (int'(req_col) < MAX_VERTICES);
   assign upd  = cand_ff && (!have_ff || (mem_rdata < best_ff));
   assign nsel = (nf_q_ff == prev_ff) ? ns_q_ff : nf_q_ff;
   assign walk_nxt = (CB'(nsel) >= n_ff) ? '0 : nsel;
   assign skip = (a_ff == c_ff) || (a_ff == tl_q_ff) || (b_ff == c_ff) || (b_ff == tl_q_ff);
   assign pk   = have_ff ? pick_ff : '0;

   always_comb begin
      case (state_ff)
         ST_J3:   alu_a = SUM_W'(wab_ff);
         ST_J5:   alu_a = SUM_W'(wac_ff);
         default: alu_a = SUM_W'(acc_ff);
      endcase
   end

   assign alu_sum = alu_a + SUM_W'(mem_rdata);
   assign acc_sat = (alu_sum > SUM_W'(COST_MAX)) ? COST_MAX : alu_sum[COST_W-1:0];
   assign better  = alu_sum[WB:0] < s1_ff;

   always_comb begin
      case (rl_ff)
         2'd0: begin
            rv = a_ff; rdrop = b_ff; radd = c_ff;
         end
         2'd1: begin
            rv = b_ff; rdrop = a_ff; radd = d_ff;
         end
         2'd2: begin
            rv = c_ff; rdrop = d_ff; radd = a_ff;
         end
         default: begin
            rv = d_ff; rdrop = c_ff; radd = b_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = (req_op == OP_LOAD) ? ST_LD2 : ST_INIT;
         end
         ST_LD2:      state_in = ST_IDLE;
         ST_INIT:     state_in = ST_NN_SCAN;
         ST_NN_SCAN:  if (i_ff == nm1) state_in = ST_NN_LAST;
         ST_NN_LAST:  state_in = ST_NN_LINK1;
         ST_NN_LINK1: state_in = ST_NN_LINK2;
         ST_NN_LINK2: state_in = have_ff ? ST_NN_SCAN : ST_W0;
         ST_W0:       state_in = ST_W1;
         ST_W1:       state_in = ST_WA;
         ST_WA:       state_in = ST_WB;
         ST_WB:       state_in = (k_ff == nm1) ? ST_WDONE : ST_WA;
         ST_WDONE:    state_in = ST_I0;
         ST_I0:       state_in = (i_ff == n_ff) ? ST_E0 : ST_I1;
         ST_I1:       state_in = ST_I2;
         ST_I2:       state_in = ST_I3;
         ST_I3:       state_in = ST_J0;
         ST_J0:       state_in = (j_ff == n_ff) ? ST_I0 : ST_J1;
         ST_J1:       state_in = ST_J2;
         ST_J2:       state_in = skip ? ST_J0 : ST_J3;
         ST_J3:       state_in = ST_J4;
         ST_J4:       state_in = ST_J5;
         ST_J5:       state_in = better ? ST_R0 : ST_J0;
         ST_R0:       state_in = ST_R1;
         ST_R1:       state_in = (rl_ff == 2'd3) ? ST_W0 : ST_R0;
         ST_E0:       state_in = ST_E1;
         ST_E1: begin
            if (out_free) state_in = (k_ff == nm1) ? ST_IDLE : ST_E0;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and store ports
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = {VB'(req_row), VB'(req_col)};
      mem_wdata = WB'(req_weight);
      mem_raddr = '0;
      nb_ra = '0;
      tl_ra = '0;
      nf_we = 1'b0; nf_wa = '0; nf_wd = '0;
      ns_we = 1'b0; ns_wa = '0; ns_wd = '0;
      tl_we = 1'b0; tl_wa = '0; tl_wd = '0;
      emit  = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_we    = req_valid && (req_op == OP_LOAD) && ld_ok;
         end
         ST_LD2: begin
            mem_we    = lok_ff;
            mem_waddr = {lcol_ff, lrow_ff};
            mem_wdata = lw_ff;
         end
         ST_NN_SCAN: mem_raddr = {v_ff, i_ff[VB-1:0]};
         ST_NN_LINK1: begin
            if ((v_ff == '0) && (k_ff == '0)) begin
               nf_we = 1'b1; nf_wa = v_ff; nf_wd = pk;
            end else begin
               ns_we = 1'b1; ns_wa = v_ff; ns_wd = pk;
            end
         end
         ST_NN_LINK2: begin
            if (have_ff) begin
               nf_we = 1'b1; nf_wa = pick_ff; nf_wd = v_ff;
            end else begin
               ns_we = 1'b1; ns_wa = '0; ns_wd = v_ff;
            end
         end
         ST_WA: nb_ra = cur_ff;
         ST_WB: begin
            tl_we = 1'b1; tl_wa = k_ff[VB-1:0]; tl_wd = cur_ff;
            mem_raddr = {cur_ff, (k_ff == nm1) ? VB'(0) : walk_nxt};
         end
         ST_I0: tl_ra = i_ff[VB-1:0];
         ST_I1: tl_ra = (i_ff == nm1) ? '0 : ip1[VB-1:0];
         ST_I2: mem_raddr = {a_ff, tl_q_ff};
         ST_J0: tl_ra = j_ff[VB-1:0];
         ST_J1: tl_ra = (j_ff == nm1) ? '0 : jp1[VB-1:0];
         ST_J2: mem_raddr = {c_ff, tl_q_ff};
         ST_J3: mem_raddr = {a_ff, c_ff};
         ST_J4: mem_raddr = {b_ff, d_ff};
         ST_R0: nb_ra = rv;
         ST_R1: begin
            nf_we = 1'b1; nf_wa = rv; nf_wd = (nf_q_ff == rdrop) ? ns_q_ff : nf_q_ff;
            ns_we = 1'b1; ns_wa = rv; ns_wd = radd;
         end
         ST_E0: tl_ra = k_ff[VB-1:0];
         ST_E1: begin
            tl_ra          = k_ff[VB-1:0];
            emit.valid     = 1'b1;
            emit.vertex    = VTX_W'(tl_q_ff);
            emit.position  = POS_W'(k_ff);
            emit.tour_cost = acc_ff;
            emit.last      = (k_ff == nm1);
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      n_in = n_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      v_in = v_ff; pick_in = pick_ff; prev_in = prev_ff; cur_in = cur_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      idx_in = idx_ff; lrow_in = lrow_ff; lcol_in = lcol_ff; lok_in = lok_ff;
      have_in = have_ff; cand_in = cand_ff; pend_in = pend_ff;
      best_in = best_ff; wab_in = wab_ff; wac_in = wac_ff; lw_in = lw_ff;
      s1_in = s1_ff; acc_in = acc_ff; rl_in = rl_ff; visited_in = visited_ff;
      case (state_ff)
         ST_IDLE: begin
            lrow_in = VB'(req_row);
            lcol_in = VB'(req_col);
            lw_in   = WB'(req_weight);
            lok_in  = ld_ok;
         end
         ST_INIT: begin
            n_in = n_active;
            visited_in = MAX_VERTICES'(1);
            v_in = '0; k_in = '0; i_in = '0;
            have_in = 1'b0; cand_in = 1'b0;
         end
         ST_NN_SCAN: begin
            if (upd) begin
               best_in = mem_rdata; pick_in = idx_ff; have_in = 1'b1;
            end
            cand_in = (i_ff[VB-1:0] != v_ff) && !visited_ff[i_ff[VB-1:0]];
            idx_in  = i_ff[VB-1:0];
            i_in    = ip1;
         end
         ST_NN_LAST: begin
            if (upd) begin
               best_in = mem_rdata; pick_in = idx_ff; have_in = 1'b1;
            end
            cand_in = 1'b0;
         end
         ST_NN_LINK2: begin
            if (have_ff) begin
               visited_in[pick_ff] = 1'b1;
               v_in = pick_ff;
               k_in = k_ff + CB'(1);
               i_in = '0;
               have_in = 1'b0;
            end
         end
         ST_W1: begin
            prev_in = ns_q_ff; cur_in = '0; k_in = '0;
            acc_in = '0; pend_in = 1'b0;
         end
         ST_WA: begin
            if (pend_ff) acc_in = acc_sat;
            pend_in = 1'b0;
         end
         ST_WB: begin
            prev_in = cur_ff; cur_in = walk_nxt;
            k_in = k_ff + CB'(1); pend_in = 1'b1;
         end
         ST_WDONE: begin
            acc_in = acc_sat; i_in = '0;
         end
         ST_I0: k_in = '0;
         ST_I1: a_in = tl_q_ff;
         ST_I2: begin
            b_in = tl_q_ff; j_in = ip1;
         end
         ST_I3: wab_in = mem_rdata;
         ST_J0: if (j_ff == n_ff) i_in = ip1;
         ST_J1: c_in = tl_q_ff;
         ST_J2: begin
            d_in = tl_q_ff;
            if (skip) j_in = jp1;
         end
         ST_J3: s1_in = alu_sum[WB:0];
         ST_J4: wac_in = mem_rdata;
         ST_J5: begin
            if (better) rl_in = '0;
            else j_in = jp1;
         end
         ST_R1: rl_in = rl_ff + 2'd1;
         ST_E1: if (out_free) k_in = k_ff + CB'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         visited_ff <= '0;
      end else begin
         state_ff   <= state_in;
         visited_ff <= visited_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      v_ff <= v_in; pick_ff <= pick_in; prev_ff <= prev_in; cur_ff <= cur_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      idx_ff <= idx_in; lrow_ff <= lrow_in; lcol_ff <= lcol_in; lok_ff <= lok_in;
      have_ff <= have_in; cand_ff <= cand_in; pend_ff <= pend_in;
      best_ff <= best_in; wab_ff <= wab_in; wac_ff <= wac_in; lw_ff <= lw_in;
      s1_ff <= s1_in; acc_ff <= acc_in; rl_ff <= rl_in;
   end

   always_ff @(posedge clock) begin
      if (nf_we) nf_ff[nf_wa] <= nf_wd;
      if (ns_we) ns_ff[ns_wa] <= ns_wd;
      if (tl_we) tl_ff[tl_wa] <= tl_wd;
      nf_q_ff <= nf_ff[nb_ra];
      ns_q_ff <= ns_ff[nb_ra];
      tl_q_ff <= tl_ff[tl_ra];
   end

   `ASSERT_CLK(a_emit_in_range, emit.valid |-> (k_ff < n_ff), "emit beyond tour length")
   `ASSERT_CLK(a_origin_visited, (state_ff == ST_NN_SCAN) |-> visited_ff[0], "origin not visited")
   `ASSERT_CLK(a_run_starts, (state_ff == ST_IDLE && req_valid && req_op == OP_RUN) |=> (state_ff == ST_INIT), "run item not started")
   `ASSERT_NEVER(a_tour_origin, state_ff == ST_E1 && k_ff == '0 && tl_q_ff != '0, "tour does not start at vertex 0")

endmodule

`default_nettype wire

[rtl/core/tsp_nearest_neighbour_two_opt_unit.sv]
// Load item: both symmetric entries written (ST_IDLE, then ST_LD2), then ready again.
// Run item: builds the nearest-neighbour start tour, walks it to fill the tour list and sum
// its cost, then runs 2-opt passes over edge pairs; each swap is followed by a fresh walk.
// Results: one vertex at a time, held while the output register is full and rsp_ready is low.
// Synchronous active-high reset clears control; weights are unknown until loaded.
// ----------------------------------------------------------------------------
// Tour search unit
// Nearest-neighbour start tour improved by first-improvement 2-opt.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_nearest_neighbour_two_opt_unit #(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [tnn2o_pkg::ROW_W-1:0]   req_row,
   input  logic [tnn2o_pkg::ROW_W-1:0]   req_col,
   input  logic [tnn2o_pkg::WIN_W-1:0]   req_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tnn2o_pkg::VTX_W-1:0]   rsp_vertex,
   output logic [tnn2o_pkg::POS_W-1:0]   rsp_position,
   output logic [tnn2o_pkg::COST_W-1:0]  rsp_tour_cost,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [tnn2o_pkg::VC_W-1:0]    csr_write_data
);

   import tnn2o_pkg::*;

   localparam int VB = $clog2(MAX_VERTICES);
   localparam int CB = $clog2(MAX_VERTICES + 1);

   logic [VC_W-1:0]        vc_ff;
   logic [CB-1:0]          n_active;
   logic                   out_free;
   rsp_item_type           emit, rsp_ff, rsp_in;
   logic                   mem_we;
   logic [2*VB-1:0]        mem_waddr, mem_raddr;
   logic [WEIGHT_BITS-1:0] mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VC_RESET;
      end else if (csr_write_enable) begin
         vc_ff <= csr_write_data;
      end
   end

   assign n_active = (vc_ff == '0) ? CB'(1) :
                     (int'(vc_ff) > MAX_VERTICES) ? CB'(MAX_VERTICES) : CB'(vc_ff);

   tnn2o_wmem #(.VB(VB), .WB(WEIGHT_BITS)) u_wmem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   tnn2o_seq #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_weight (req_weight),
      .n_active   (n_active),
      .out_free   (out_free),
      .emit       (emit),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   assign out_free = !rsp_ff.valid || rsp_ready;

   always_comb begin
      rsp_in = rsp_ff;
      if (out_free) begin
         rsp_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.vertex    <= rsp_in.vertex;
      rsp_ff.position  <= rsp_in.position;
      rsp_ff.tour_cost <= rsp_in.tour_cost;
      rsp_ff.last      <= rsp_in.last;
   end

   assign rsp_valid     = rsp_ff.valid;
   assign rsp_vertex    = rsp_ff.vertex;
   assign rsp_position  = rsp_ff.position;
   assign rsp_tour_cost = rsp_ff.tour_cost;
   assign rsp_last      = rsp_ff.last;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tour search unit testbench
// Loads symmetric weight matrices through the request channel, runs the
// nearest-neighbour plus 2-opt search at several vertex counts and checks
// every emitted tour vertex, position, cost and last flag against an
// in-bench predictor. The request channel idles and the response channel stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
   import tnn2o_pkg::*;

   localparam int NV         = 32;
   localparam int IDLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT = 12;

   typedef struct {
      bit [VTX_W-1:0]  vertex;
      bit [POS_W-1:0]  position;
      bit [COST_W-1:0] tour_cost;
      bit              last;
   } tour_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_op = OP_LOAD;
   logic [ROW_W-1:0]  req_row = '0;
   logic [ROW_W-1:0]  req_col = '0;
   logic [WIN_W-1:0]  req_weight = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [VTX_W-1:0]  rsp_vertex;
   logic [POS_W-1:0]  rsp_position;
   logic [COST_W-1:0] rsp_tour_cost;
   logic              rsp_last;
   logic              csr_write_enable = 1'b0;
   logic [VC_W-1:0]   csr_write_data = '0;

   tour_entry_type expected_tour[$];
   int          error_count = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;

   bit [WIN_W-1:0] wmat[NV][NV];
   bit [VTX_W-1:0] nb_first[NV];
   bit [VTX_W-1:0] nb_second[NV];
   bit [VTX_W-1:0] walk_order[NV];
   bit             seen[NV];
   int             slot_fill[NV];
   bit [VC_W-1:0]  vertex_count_reg = VC_RESET;

   int             ready_mode = 0;
   int             ready_tick = 0;

   tsp_nearest_neighbour_two_opt_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_weight       (req_weight),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex       (rsp_vertex),
      .rsp_position     (rsp_position),
      .rsp_tour_cost    (rsp_tour_cost),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------ predictor
   function automatic int active_vertices();
      if (vertex_count_reg == 0) return 1;
      if (vertex_count_reg > NV) return NV;
      return int'(vertex_count_reg);
   endfunction

   function automatic void link_neighbour(int v, int other);
      if (slot_fill[v] == 0) nb_first[v] = other[VTX_W-1:0];
      else nb_second[v] = other[VTX_W-1:0];
      if (slot_fill[v] < 2) slot_fill[v]++;
   endfunction

   function automatic void build_nearest(int n);
      int  v;
      int  pick;
      bit  have;
      bit  closed;
      v = 0;
      closed = 0;
      for (int i = 0; i < NV; i++) begin
         slot_fill[i] = 0;
         seen[i] = 0;
      end
      while (!closed) begin
         seen[v] = 1;
         have = 0;
         pick = 0;
         for (int i = 0; i < n; i++) begin
            if (i != v && !seen[i]) begin
               if (!have || wmat[v][i] < wmat[v][pick]) begin
                  pick = i;
                  have = 1;
               end
            end
         end
         if (!have) begin
            pick = 0;
            closed = 1;
         end
         link_neighbour(v, pick);
         link_neighbour(pick, v);
         v = pick;
      end
   endfunction

   function automatic void walk_cycle(int n);
      int cur;
      int prev;
      int nxt;
      cur = 0;
      prev = nb_second[0];
      for (int k = 0; k < n; k++) begin
         nxt = (nb_first[cur] == prev) ? nb_second[cur] : nb_first[cur];
         if (nxt >= n) nxt = 0;
         walk_order[k] = cur[VTX_W-1:0];
         prev = cur;
         cur = nxt;
      end
   endfunction

   function automatic void swap_link(int v, int drop, int add);
      if (nb_first[v] == drop) nb_first[v] = nb_second[v];
      nb_second[v] = add[VTX_W-1:0];
   endfunction

   function automatic bit improve_pass(int n);
      int a, b, c, d;
      walk_cycle(n);
      for (int i = 0; i < n; i++) begin
         a = walk_order[i];
         b = walk_order[(i + 1) % n];
         for (int j = i + 1; j < n; j++) begin
            c = walk_order[j];
            d = walk_order[(j + 1) % n];
            if (a == c || a == d || b == c || b == d) continue;
            if (int'(wmat[a][c]) + int'(wmat[b][d]) <
                int'(wmat[a][b]) + int'(wmat[c][d])) begin
               swap_link(a, b, c);
               swap_link(b, a, d);
               swap_link(c, d, a);
               swap_link(d, c, b);
               return 1;
            end
         end
      end
      return 0;
   endfunction

   function automatic void predict_tour();
      int          n;
      longint      total;
      bit [COST_W-1:0] cost;
      tour_entry_type e;
      n = active_vertices();
      build_nearest(n);
      while (improve_pass(n)) begin
      end
      walk_cycle(n);
      total = 0;
      for (int k = 0; k < n; k++)
         total += wmat[walk_order[k]][walk_order[(k + 1) % n]];
      cost = (total > COST_MAX) ? COST_MAX : total[COST_W-1:0];
      for (int k = 0; k < n; k++) begin
         e.vertex = walk_order[k];
         e.position = k[POS_W-1:0];
         e.tour_cost = cost;
         e.last = (k + 1 == n);
         expected_tour = {expected_tour, e};
      end
   endfunction

   // ------------------------------------------------------------ checking
   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   always @(negedge clock) begin
      tour_entry_type e;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** tsp_nearest_neighbour_two_opt_unit: FAILED **");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tour.size() == 0) begin
            report_mismatch($sformatf("unexpected item vertex %0d", rsp_vertex));
         end else begin
            e = expected_tour.pop_front();
            if (rsp_vertex !== e.vertex)
               report_mismatch($sformatf("vertex %0d, want %0d", rsp_vertex, e.vertex));
            if (rsp_position !== e.position)
               report_mismatch($sformatf("position %0d, want %0d",
                                         rsp_position, e.position));
            if (rsp_tour_cost !== e.tour_cost)
               report_mismatch($sformatf("tour_cost %0d, want %0d",
                                         rsp_tour_cost, e.tour_cost));
            if (rsp_last !== e.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_last, e.last));
         end
      end
   end

   always @(posedge clock) begin
      if (ready_tick == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_tick <= $urandom_range(16, 128);
      end else begin
         ready_tick <= ready_tick - 1;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= 1'b0;
      endcase
   end

   // ------------------------------------------------------------ stimulus
   task automatic send_item(logic op, int row, int col, int w);
      req_valid  <= 1'b1;
      req_op     <= op;
      req_row    <= row[ROW_W-1:0];
      req_col    <= col[ROW_W-1:0];
      req_weight <= w[WIN_W-1:0];
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      items_sent++;
      if (op == OP_LOAD) begin
         wmat[row][col] = w[WIN_W-1:0];
         wmat[col][row] = w[WIN_W-1:0];
      end else begin
         predict_tour();
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic load_weight(int row, int col, int w);
      send_item(OP_LOAD, row, col, w);
   endtask

   task automatic fill_matrix(int n, int w_lo, int w_hi);
      for (int r = 0; r < n; r++)
         for (int c = r; c < n; c++)
            load_weight(r, c, $urandom_range(w_lo, w_hi));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_tour.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_vertex_count(int vc);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= vc[VC_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vertex_count_reg = vc[VC_W-1:0];
   endtask

   // ------------------------------------------------------------ tests
   task automatic test_degenerate_counts();
      set_vertex_count(0);
      load_weight(0, 0, 16'hFFFF);
      send_item(OP_RUN, 0, 0, 0);
      set_vertex_count(1);
      load_weight(0, 0, 0);
      send_item(OP_RUN, 0, 0, 0);
      set_vertex_count(2);
      load_weight(0, 1, 16'hFFFF);
      load_weight(1, 1, 16'h1234);
      send_item(OP_RUN, 0, 0, 0);
   endtask

   task automatic test_tie_break();
      set_vertex_count(5);
      fill_matrix(5, 7, 7);
      send_item(OP_RUN, 0, 0, 0);
      load_weight(0, 4, 1);
      load_weight(2, 3, 0);
      load_weight(1, 3, 2);
      send_item(OP_RUN, 0, 0, 0);
   endtask

   task automatic test_random_traffic();
      int start;
      int n;
      int w_hi;
      start = items_sent;
      while (items_sent - start < 170) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12)
                                         : $urandom_range(3, 8);
         w_hi = ($urandom_range(0, 2) == 0) ? 3 : 16'hFFFF;
         set_vertex_count(n);
         fill_matrix(n, 0, w_hi);
         repeat ($urandom_range(0, 2))
            load_weight($urandom_range(0, 31), $urandom_range(0, 31), $urandom);
         send_item(OP_RUN, 0, 0, 0);
         repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 4))
               load_weight($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                           $urandom_range(0, w_hi));
            send_item(OP_RUN, 0, 0, 0);
         end
      end
   endtask

   initial begin
      for (int r = 0; r < NV; r++)
         for (int c = 0; c < NV; c++)
            wmat[r][c] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_degenerate_counts();
      test_tie_break();
      test_random_traffic();
      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("** tsp_nearest_neighbour_two_opt_unit: PASSED **");
      end else begin
         $display("** tsp_nearest_neighbour_two_opt_unit: FAILED **");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/tnn2o_pkg.sv
rtl/core/tnn2o_wmem.sv
rtl/core/tnn2o_seq.sv
rtl/core/tsp_nearest_neighbour_two_opt_unit.sv
dv/tb_top.sv
